/* rtl/core/npqb_pkg.sv */
// ----------------------------------------------------------------------------
// npqb_pkg
// shared constants, the job record between front and back, and a sign helper
// ----------------------------------------------------------------------------
package npqb_pkg;

	localparam int COORD_BITS  = 16;
	localparam int DEPTH_LIMIT = 24;
	localparam int T_FRAC      = 24;
	localparam int OUT_FRAC    = 8;
	localparam int GUARD_BITS  = 58 - 2 * COORD_BITS;
	localparam int U_FRAC      = DEPTH_LIMIT + 1;
	localparam int LEVELS      = DEPTH_LIMIT + 2;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * DIFF_BITS;
	localparam int DOT_BITS    = PROD_BITS + 1;
	localparam int WRAW_BITS   = DOT_BITS + 2;
	localparam int W_BITS      = 63;
	localparam int OUT_BITS    = COORD_BITS + OUT_FRAC;
	localparam int DIST_BITS   = 25;
	localparam int DSQ_BITS    = 50;
	localparam int DEPTH_BITS  = $clog2(DEPTH_LIMIT + 1);
	localparam int SP_BITS     = $clog2(LEVELS);

	// one classified item, as handed from front to back
	typedef struct packed {
		logic signed [COORD_BITS-1:0] q_x;
		logic signed [COORD_BITS-1:0] q_y;
		logic signed [COORD_BITS-1:0] s_x;
		logic signed [COORD_BITS-1:0] s_y;
		logic signed [COORD_BITS-1:0] c_x;
		logic signed [COORD_BITS-1:0] c_y;
		logic signed [COORD_BITS-1:0] e_x;
		logic signed [COORD_BITS-1:0] e_y;
		logic signed [WRAW_BITS-1:0]  w0;
		logic signed [WRAW_BITS-1:0]  w1;
		logic signed [WRAW_BITS-1:0]  w2;
		logic signed [WRAW_BITS-1:0]  w3;
		logic signed [OUT_BITS-1:0]   best_x;
		logic signed [OUT_BITS-1:0]   best_y;
		logic [DSQ_BITS-1:0]          best_dsq;
		logic                         has_roots;
	} job_t;

	// any sign change among four control values, given their sign bits
	function automatic logic any_flip(input logic [3:0] neg);
		return (neg[0] ^ neg[1]) | (neg[1] ^ neg[2]) | (neg[2] ^ neg[3]);
	endfunction

endpackage

/* rtl/core/npqb_front.sv */
// ----------------------------------------------------------------------------
// npqb_front
// takes an item, forms the bernstein values and end point distances, classifies
// ----------------------------------------------------------------------------
module npqb_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  query_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  query_y,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  start_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  start_y,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  ctrl_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  ctrl_y,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  end_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0]  end_y,
	input  logic                                    full,
	output logic                                    push,
	output npqb_pkg::job_t                          job
);
	import npqb_pkg::*;

	localparam logic [4:0] MUL_STEPS = 5'd16;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

	fstate_t state_q;
	logic [4:0] step_q;
	logic       acc_en_q;
	logic [3:0] tag_q;

	logic signed [COORD_BITS-1:0] qx_q, qy_q, sx_q, sy_q, cx_q, cy_q, ex_q, ey_q;
	logic signed [PROD_BITS-1:0]  prod_q;
	logic signed [WRAW_BITS-1:0]  w0_q, w1_q, w2_q, w3_q;
	logic signed [DOT_BITS-1:0]   e0_q, e1_q;

	logic signed [DIFF_BITS-1:0] cx0, cy0, cx1, cy1, cx2, cy2, dx0, dy0, dx1, dy1;
	logic signed [DIFF_BITS-1:0] ma, mb;
	logic signed [WRAW_BITS-1:0] pw, pw2, pw3;
	logic start_near;

	assign cx0 = DIFF_BITS'(sx_q) - DIFF_BITS'(qx_q);
	assign cy0 = DIFF_BITS'(sy_q) - DIFF_BITS'(qy_q);
	assign cx1 = DIFF_BITS'(cx_q) - DIFF_BITS'(qx_q);
	assign cy1 = DIFF_BITS'(cy_q) - DIFF_BITS'(qy_q);
	assign cx2 = DIFF_BITS'(ex_q) - DIFF_BITS'(qx_q);
	assign cy2 = DIFF_BITS'(ey_q) - DIFF_BITS'(qy_q);
	assign dx0 = DIFF_BITS'(cx_q) - DIFF_BITS'(sx_q);
	assign dy0 = DIFF_BITS'(cy_q) - DIFF_BITS'(sy_q);
	assign dx1 = DIFF_BITS'(ex_q) - DIFF_BITS'(cx_q);
	assign dy1 = DIFF_BITS'(ey_q) - DIFF_BITS'(cy_q);

	// product schedule: twelve dot-product terms, then the two end distances
	always_comb begin
		unique case (step_q[3:0])
			4'd0:    begin ma = dx0; mb = cx0; end
			4'd1:    begin ma = dy0; mb = cy0; end
			4'd2:    begin ma = dx1; mb = cx0; end
			4'd3:    begin ma = dy1; mb = cy0; end
			4'd4:    begin ma = dx0; mb = cx1; end
			4'd5:    begin ma = dy0; mb = cy1; end
			4'd6:    begin ma = dx1; mb = cx1; end
			4'd7:    begin ma = dy1; mb = cy1; end
			4'd8:    begin ma = dx0; mb = cx2; end
			4'd9:    begin ma = dy0; mb = cy2; end
			4'd10:   begin ma = dx1; mb = cx2; end
			4'd11:   begin ma = dy1; mb = cy2; end
			4'd12:   begin ma = cx0; mb = cx0; end
			4'd13:   begin ma = cy0; mb = cy0; end
			4'd14:   begin ma = cx2; mb = cx2; end
			default: begin ma = cy2; mb = cy2; end
		endcase
	end

	assign pw  = WRAW_BITS'(prod_q);
	assign pw2 = pw <<< 1;
	assign pw3 = pw + pw2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			step_q   <= '0;
			acc_en_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					acc_en_q <= 1'b0;
					step_q   <= '0;
					if (start) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					acc_en_q <= (step_q != MUL_STEPS);
					if (step_q == MUL_STEPS) begin
						state_q <= F_PUSH;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				F_PUSH: begin
					acc_en_q <= 1'b0;
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			qx_q <= query_x; qy_q <= query_y;
			sx_q <= start_x; sy_q <= start_y;
			cx_q <= ctrl_x;  cy_q <= ctrl_y;
			ex_q <= end_x;   ey_q <= end_y;
			w0_q <= '0; w1_q <= '0; w2_q <= '0; w3_q <= '0;
			e0_q <= '0; e1_q <= '0;
		end else begin
			if (state_q == F_MUL) begin
				prod_q <= ma * mb;
				tag_q  <= step_q[3:0];
			end
			if (acc_en_q) begin
				case (tag_q) inside
					4'd0, 4'd1:                w0_q <= w0_q + pw3;
					4'd2, 4'd3:                w1_q <= w1_q + pw;
					4'd4, 4'd5:                w1_q <= w1_q + pw2;
					4'd6, 4'd7:                w2_q <= w2_q + pw2;
					4'd8, 4'd9:                w2_q <= w2_q + pw;
					4'd10, 4'd11:              w3_q <= w3_q + pw3;
					4'd12, 4'd13:              e0_q <= e0_q + DOT_BITS'(prod_q);
					default:                   e1_q <= e1_q + DOT_BITS'(prod_q);
				endcase
			end
		end
	end

	// start point wins only when strictly nearer
	assign start_near = e0_q < e1_q;

	always_comb begin
		job.q_x       = qx_q; job.q_y = qy_q;
		job.s_x       = sx_q; job.s_y = sy_q;
		job.c_x       = cx_q; job.c_y = cy_q;
		job.e_x       = ex_q; job.e_y = ey_q;
		job.w0        = w0_q; job.w1 = w1_q; job.w2 = w2_q; job.w3 = w3_q;
		job.best_x    = start_near ? {sx_q, {OUT_FRAC{1'b0}}} : {ex_q, {OUT_FRAC{1'b0}}};
		job.best_y    = start_near ? {sy_q, {OUT_FRAC{1'b0}}} : {ey_q, {OUT_FRAC{1'b0}}};
		job.best_dsq  = start_near ? {e0_q[DSQ_BITS-17:0], 16'd0}
		                           : {e1_q[DSQ_BITS-17:0], 16'd0};
		job.has_roots = any_flip({w3_q[WRAW_BITS-1], w2_q[WRAW_BITS-1],
		                          w1_q[WRAW_BITS-1], w0_q[WRAW_BITS-1]});
	end

	assign push = (state_q == F_PUSH) && !full;
	assign busy = (state_q != F_IDLE);

endmodule

/* rtl/core/npqb_fifo.sv */
// ----------------------------------------------------------------------------
// npqb_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module npqb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  npqb_pkg::job_t wr_data,
	output logic           full,
	input  logic           pop,
	output npqb_pkg::job_t rd_data,
	output logic           empty
);
	import npqb_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	assign rd_data = mem_q[rp_q];
	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);

endmodule

/* rtl/core/npqb_back.sv */
// ----------------------------------------------------------------------------
// npqb_back
// root search by subdivision, curve evaluation at roots, integer square root
// ----------------------------------------------------------------------------
module npqb_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 empty,
	input  npqb_pkg::job_t                       rd_data,
	output logic                                 pop,
	output logic                                 done,
	output logic signed [npqb_pkg::OUT_BITS-1:0] nearest_x,
	output logic signed [npqb_pkg::OUT_BITS-1:0] nearest_y,
	output logic [npqb_pkg::DIST_BITS-1:0]       distance
);
	import npqb_pkg::*;

	localparam int MA_BITS = 44;
	localparam int MB_BITS = 18;
	localparam int MP_BITS = MA_BITS + MB_BITS;
	localparam int CA_BITS = 66;
	localparam int DA_BITS = DSQ_BITS + 2;
	localparam int SQ_BITS = DSQ_BITS + 1;

	typedef enum logic [4:0] {
		B_IDLE, B_EVAL, B_SPL1, B_SPL2, B_SPL3, B_POP,
		B_L0, B_L1, B_L2, B_L3, B_L4, B_L5,
		B_D0, B_D1, B_D2, B_D3, B_D4, B_D5,
		B_SQRT
	} bstate_t;

	typedef struct packed {
		logic signed [W_BITS-1:0] w0;
		logic signed [W_BITS-1:0] w1;
		logic signed [W_BITS-1:0] w2;
		logic signed [W_BITS-1:0] w3;
		logic [U_FRAC-1:0]        st;
		logic [DEPTH_BITS-1:0]    dep;
	} frame_t;

	bstate_t state_q;
	logic [SP_BITS-1:0] sp_q;
	logic ysel_q;
	logic done_q;

	job_t job_q;
	frame_t stk_q [LEVELS];
	logic signed [W_BITS-1:0] w0_q, w1_q, w2_q, w3_q;
	logic signed [W_BITS-1:0] a01_q, a12_q, a23_q, b0_q, b1_q;
	logic [U_FRAC-1:0]     st_q;
	logic [DEPTH_BITS-1:0] dep_q;
	logic [T_FRAC-1:0]     t_q;
	logic signed [MP_BITS-1:0] prod_q;
	logic signed [MA_BITS-1:0] ta_q;
	logic signed [CA_BITS-1:0] cacc_q;
	logic signed [DA_BITS-1:0] dacc_q;
	logic signed [OUT_BITS-1:0] rx_q, ry_q, bx_q, by_q;
	logic [DSQ_BITS-1:0] bd_q;
	logic [SQ_BITS-1:0] sq_v_q, sq_res_q, sq_one_q;
	logic signed [OUT_BITS-1:0] nx_q, ny_q;
	logic [DIST_BITS-1:0] dist_q;

	// floor of the mean of two control values
	function automatic logic signed [W_BITS-1:0] hf(input logic signed [W_BITS-1:0] a,
	                                                input logic signed [W_BITS-1:0] b);
		logic signed [W_BITS:0] s;
		s = (W_BITS+1)'(a) + (W_BITS+1)'(b);
		return s[W_BITS:1];
	endfunction

	logic flip, at_leaf, t_ok, better, sp_zero, sq_ge, sq_end;
	logic [U_FRAC:0] tu;
	logic [U_FRAC-1:0] tt;
	logic signed [W_BITS-1:0] mid;
	logic signed [COORD_BITS-1:0] p0, p1, p2;
	logic signed [DIFF_BITS-1:0] dp;
	logic signed [MB_BITS-1:0] a2;
	logic signed [OUT_BITS:0] dxw, dyw, dsel;
	logic signed [MA_BITS-1:0] mul_a;
	logic signed [MB_BITS-1:0] mul_b;
	logic signed [MP_BITS-1:0] mul_p;
	logic signed [CA_BITS-1:0] rnd;
	logic [SQ_BITS-1:0] sq_sum;
	frame_t top_f;

	assign flip    = any_flip({w3_q[W_BITS-1], w2_q[W_BITS-1], w1_q[W_BITS-1], w0_q[W_BITS-1]});
	assign at_leaf = (dep_q >= DEPTH_BITS'(DEPTH_LIMIT));
	// root is the interval midpoint, cut to the t grid
	assign tu      = (U_FRAC+1)'(st_q) + (U_FRAC+1)'(1);
	assign tt      = tu[U_FRAC:U_FRAC-T_FRAC];
	assign t_ok    = (tt != '0) && !tt[T_FRAC];
	assign mid     = hf(b0_q, b1_q);
	assign sp_zero = (sp_q == '0);
	assign top_f   = stk_q[sp_q - SP_BITS'(1)];
	assign better  = dacc_q[DSQ_BITS-1:0] < bd_q;

	assign p0 = ysel_q ? job_q.s_y : job_q.s_x;
	assign p1 = ysel_q ? job_q.c_y : job_q.c_x;
	assign p2 = ysel_q ? job_q.e_y : job_q.e_x;
	assign dp = DIFF_BITS'(p1) - DIFF_BITS'(p0);
	assign a2 = MB_BITS'(p0) - (MB_BITS'(p1) <<< 1) + MB_BITS'(p2);

	assign dxw  = (OUT_BITS+1)'(rx_q) - ((OUT_BITS+1)'(job_q.q_x) <<< OUT_FRAC);
	assign dyw  = (OUT_BITS+1)'(ry_q) - ((OUT_BITS+1)'(job_q.q_y) <<< OUT_FRAC);
	assign dsel = (state_q == B_D2 || state_q == B_D3) ? dyw : dxw;

	always_comb begin
		unique case (state_q)
			B_L0:       begin mul_a = MA_BITS'(signed'({1'b0, t_q})); mul_b = MB_BITS'(dp); end
			B_L1:       begin mul_a = MA_BITS'(signed'({1'b0, t_q})); mul_b = a2; end
			B_L2:       begin mul_a = prod_q[MA_BITS-1:0]; mul_b = {6'd0, t_q[11:0]}; end
			B_L3:       begin mul_a = ta_q; mul_b = {6'd0, t_q[23:12]}; end
			B_D0, B_D2: begin mul_a = MA_BITS'(dsel); mul_b = {6'd0, dsel[11:0]}; end
			B_D1, B_D3: begin mul_a = MA_BITS'(dsel); mul_b = MB_BITS'(dsel >>> 12); end
			default:    begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign rnd    = cacc_q + (CA_BITS'(1) <<< 39);
	assign sq_sum = sq_res_q + sq_one_q;
	assign sq_ge  = sq_v_q >= sq_sum;
	assign sq_end = (sq_one_q == '0);

	assign pop = (state_q == B_IDLE) && !empty;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sp_q    <= '0;
			ysel_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					sp_q   <= '0;
					ysel_q <= 1'b0;
					if (!empty) begin
						state_q <= rd_data.has_roots ? B_EVAL : B_SQRT;
					end
				end
				B_EVAL: begin
					if (!flip) begin
						state_q <= B_POP;
					end else if (at_leaf) begin
						state_q <= t_ok ? B_L0 : B_POP;
					end else begin
						state_q <= B_SPL1;
					end
				end
				B_SPL1: state_q <= B_SPL2;
				B_SPL2: state_q <= B_SPL3;
				B_SPL3: begin
					sp_q    <= sp_q + SP_BITS'(1);
					state_q <= B_EVAL;
				end
				B_POP: begin
					if (sp_zero) begin
						state_q <= B_SQRT;
					end else begin
						sp_q    <= sp_q - SP_BITS'(1);
						state_q <= B_EVAL;
					end
				end
				B_L0: state_q <= B_L1;
				B_L1: state_q <= B_L2;
				B_L2: state_q <= B_L3;
				B_L3: state_q <= B_L4;
				B_L4: state_q <= B_L5;
				B_L5: begin
					ysel_q  <= !ysel_q;
					state_q <= ysel_q ? B_D0 : B_L0;
				end
				B_D0: state_q <= B_D1;
				B_D1: state_q <= B_D2;
				B_D2: state_q <= B_D3;
				B_D3: state_q <= B_D4;
				B_D4: state_q <= B_D5;
				B_D5: state_q <= B_POP;
				B_SQRT: begin
					if (sq_end) begin
						done_q  <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			B_IDLE: begin
				job_q    <= rd_data;
				w0_q     <= W_BITS'(rd_data.w0) <<< GUARD_BITS;
				w1_q     <= W_BITS'(rd_data.w1) <<< GUARD_BITS;
				w2_q     <= W_BITS'(rd_data.w2) <<< GUARD_BITS;
				w3_q     <= W_BITS'(rd_data.w3) <<< GUARD_BITS;
				st_q     <= '0;
				dep_q    <= '0;
				bx_q     <= rd_data.best_x;
				by_q     <= rd_data.best_y;
				bd_q     <= rd_data.best_dsq;
				sq_v_q   <= SQ_BITS'(rd_data.best_dsq);
				sq_res_q <= '0;
				sq_one_q <= SQ_BITS'(1) << (DSQ_BITS - 2);
			end
			B_EVAL: t_q <= tt[T_FRAC-1:0];
			B_SPL1: begin
				a01_q <= hf(w0_q, w1_q);
				a12_q <= hf(w1_q, w2_q);
				a23_q <= hf(w2_q, w3_q);
			end
			B_SPL2: begin
				b0_q <= hf(a01_q, a12_q);
				b1_q <= hf(a12_q, a23_q);
			end
			B_SPL3: begin
				// right half waits on the stack, left half goes on at once
				stk_q[sp_q] <= '{w0: mid, w1: b1_q, w2: a23_q, w3: w3_q,
				                 st: st_q + (U_FRAC'(1) << (DEPTH_BITS'(DEPTH_LIMIT) - dep_q)),
				                 dep: dep_q + DEPTH_BITS'(1)};
				w1_q  <= a01_q;
				w2_q  <= b0_q;
				w3_q  <= mid;
				dep_q <= dep_q + DEPTH_BITS'(1);
			end
			B_POP: begin
				if (sp_zero) begin
					sq_v_q   <= SQ_BITS'(bd_q);
					sq_res_q <= '0;
					sq_one_q <= SQ_BITS'(1) << (DSQ_BITS - 2);
				end else begin
					w0_q  <= top_f.w0;
					w1_q  <= top_f.w1;
					w2_q  <= top_f.w2;
					w3_q  <= top_f.w3;
					st_q  <= top_f.st;
					dep_q <= top_f.dep;
				end
			end
			B_L1: cacc_q <= (CA_BITS'(p0) <<< (2 * T_FRAC)) + (CA_BITS'(prod_q) <<< (T_FRAC + 1));
			B_L2: ta_q <= prod_q[MA_BITS-1:0];
			B_L3: cacc_q <= cacc_q + CA_BITS'(prod_q);
			B_L4: cacc_q <= cacc_q + (CA_BITS'(prod_q) <<< 12);
			B_L5: begin
				if (ysel_q) ry_q <= rnd[63:40];
				else        rx_q <= rnd[63:40];
			end
			B_D1: dacc_q <= DA_BITS'(prod_q);
			B_D2: dacc_q <= dacc_q + (DA_BITS'(prod_q) <<< 12);
			B_D3: dacc_q <= dacc_q + DA_BITS'(prod_q);
			B_D4: dacc_q <= dacc_q + (DA_BITS'(prod_q) <<< 12);
			B_D5: begin
				if (better) begin
					bd_q <= dacc_q[DSQ_BITS-1:0];
					bx_q <= rx_q;
					by_q <= ry_q;
				end
			end
			B_SQRT: begin
				if (sq_end) begin
					nx_q   <= bx_q;
					ny_q   <= by_q;
					dist_q <= sq_res_q[DIST_BITS-1:0];
				end else begin
					if (sq_ge) begin
						sq_v_q   <= sq_v_q - sq_sum;
						sq_res_q <= (sq_res_q >> 1) + sq_one_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_one_q <= sq_one_q >> 2;
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign nearest_x = nx_q;
	assign nearest_y = ny_q;
	assign distance  = dist_q;

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_BITS'(DEPTH_LIMIT))
		else $error("subdivision stack over its bound");

	a_dep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_IDLE |-> dep_q <= DEPTH_BITS'(DEPTH_LIMIT))
		else $error("interval depth over its bound");

	a_split_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SPL3 |=> state_q == B_EVAL && dep_q == $past(dep_q) + DEPTH_BITS'(1))
		else $error("split did not go one level deeper");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == B_SQRT) && state_q == B_IDLE)
		else $error("result strobe outside square root exit");
`endif

endmodule

/* rtl/core/nearest_point_on_quadratic_bezier_top.sv */
// ----------------------------------------------------------------------------
// nearest_point_on_quadratic_bezier_top
// nearest point on a quadratic bezier curve to a query point, and its distance
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  input    | start, busy      | query_x/y, start_x/y, ctrl_x/y, end_x/y
//  result   | done (1 cycle)   | nearest_x, nearest_y, distance
//
//  an item transfers when start is high and busy is low; busy stays high
//  while the front forms the polynomial, longer if the job queue is full
//  the back evaluates and splits intervals down to 24 levels per root,
//  evaluates the curve at each root found and ends with an integer square
//  root; an item with no root goes straight to the square root, and all of
//  it runs under the single subdivision and multiply sequencer, which
//  takes a new job from the queue only when idle
//  arst_n clears all control state; the queue holds up to two classified jobs
//  done pulses for one cycle; the receiver cannot stall it
// ----------------------------------------------------------------------------
module nearest_point_on_quadratic_bezier_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] query_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] query_y,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] start_y,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] ctrl_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] ctrl_y,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] end_x,
	input  logic signed [npqb_pkg::COORD_BITS-1:0] end_y,
	output logic                                  done,
	output logic signed [npqb_pkg::OUT_BITS-1:0]  nearest_x,
	output logic signed [npqb_pkg::OUT_BITS-1:0]  nearest_y,
	output logic [npqb_pkg::DIST_BITS-1:0]        distance
);
	import npqb_pkg::*;

	// job handoff between front and back
	job_t wr_job, rd_job;
	logic push, full, pop, empty;

	// front: input transfer, bernstein values, end point pick
	npqb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.query_x (query_x),
		.query_y (query_y),
		.start_x (start_x),
		.start_y (start_y),
		.ctrl_x  (ctrl_x),
		.ctrl_y  (ctrl_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.full    (full),
		.push    (push),
		.job     (wr_job)
	);

	// queue lets the front take the next item while the back searches
	npqb_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_job),
		.full    (full),
		.pop     (pop),
		.rd_data (rd_job),
		.empty   (empty)
	);

	// back: root search, curve evaluation, square root, result strobe
	npqb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.rd_data   (rd_job),
		.pop       (pop),
		.done      (done),
		.nearest_x (nearest_x),
		.nearest_y (nearest_y),
		.distance  (distance)
	);

endmodule
